[rtl/ffila_pkg.sv]
// Shared types and constants for the first-fit interval layer assignment block.
// No dependencies; used by the interfaces, the RAM user and the top level.
package ffila_pkg;

	localparam int unsigned TIME_W  = 24;
	localparam int unsigned LAYER_W = 6;
	localparam int unsigned Y_W     = 15;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned SUM_W   = CFG_W + 1;
	localparam int unsigned LAYERS  = 64;
	localparam int unsigned GRP_W   = 3;
	localparam int unsigned GRP_N   = 8;
	localparam int unsigned ENTRY_W = TIME_W + LAYER_W;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_BOX_HEIGHT = 1'b0;
	localparam logic REG_BOX_GAP    = 1'b1;

	localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = 8'd20;
	localparam logic [CFG_W-1:0] BOX_GAP_RST    = 8'd3;

	localparam logic [GRP_W-1:0]   GRP_LAST  = 3'd7;
	localparam logic [LAYER_W-1:0] LAYER_TOP = 6'd63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_CALC,
		ST_DONE
	} state_t;

	// Position of the lowest clear bit in a byte (byte assumed not all ones)
	function automatic logic [GRP_W-1:0] lowest_zero8(input logic [GRP_N-1:0] b);
		logic [GRP_W-1:0] pos;
		pos = '0;
		for (int i = GRP_N - 1; i >= 0; i--) begin
			if (!b[i]) begin
				pos = GRP_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

[rtl/ffila_if.sv]
// Valid/ready channel interfaces for interval items and result items.
// Depends on ffila_pkg for field widths.
interface ffila_in_if;
	logic                              valid;
	logic                              ready;
	logic [ffila_pkg::TIME_W-1:0]      start_time;
	logic [ffila_pkg::TIME_W-1:0]      finish_time;
	logic                              is_first;

	modport source (output valid, start_time, finish_time, is_first, input ready);
	modport sink   (input valid, start_time, finish_time, is_first, output ready);
endinterface

interface ffila_out_if;
	logic                              valid;
	logic                              ready;
	logic [ffila_pkg::LAYER_W-1:0]     layer;
	logic [ffila_pkg::Y_W-1:0]         top_y;
	logic [ffila_pkg::Y_W-1:0]         bottom_y;
	logic [ffila_pkg::LAYER_W-1:0]     max_layer;
	logic                              overflow;

	modport source (output valid, layer, top_y, bottom_y, max_layer, overflow, input ready);
	modport sink   (input valid, layer, top_y, bottom_y, max_layer, overflow, output ready);
endinterface

[rtl/ffila_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffila_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/first_fit_interval_layer_assign_top.sv]
// First-fit interval layer assignment, top level: sequencer, compare unit and output register.
// Depends on ffila_pkg, ffila_if (ffila_in_if, ffila_out_if) and ffila_ram.
//
// Intervals arrive one item at a time. Each stored earlier interval of the current set
// (its finish time and layer live in a RAM of MAX_ITEMS entries) is read once, one entry
// per cycle, and a single 24-bit comparator marks its layer blocked when its finish lies
// after the new start. A byte-wide search then finds the lowest free layer of 64, a
// single 6x9 multiplier forms top_y, and an adder forms bottom_y. After acceptance an
// item goes through the RAM sweep over the N stored intervals (at most MAX_ITEMS), the
// free-layer search, which looks at one byte of layers at a time, and the multiply, and
// then into the output register; the RAM read port paces the sweep. in_item.ready is
// high only while the sequencer is idle; a finished result may wait in the output
// register while the next item is taken. is_first restarts the set.
// Once the store holds MAX_ITEMS intervals, further items are still assigned a layer but
// are flagged with overflow and not stored. The RAM needs no clearing after reset.
module first_fit_interval_layer_assign_top #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ffila_in_if.sink                            in_item,
	ffila_out_if.source                         out_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ffila_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ffila_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ffila_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned AW = $clog2(MAX_ITEMS);

	// Configuration registers
	logic [ffila_pkg::CFG_W-1:0] box_height_q;
	logic [ffila_pkg::CFG_W-1:0] box_gap_q;
	logic                        cfg_wr;

	// Sequencer state
	ffila_pkg::state_t state_q, state_d;

	// Item and scan registers
	logic [ffila_pkg::TIME_W-1:0]  start_q;
	logic [ffila_pkg::TIME_W-1:0]  finish_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 idx_q;
	logic                          pend_q;
	logic [ffila_pkg::LAYERS-1:0]  blocked_q;
	logic [ffila_pkg::GRP_W-1:0]   grp_q;
	logic [ffila_pkg::LAYER_W-1:0] layer_q;
	logic [ffila_pkg::LAYER_W-1:0] highest_q;
	logic [ffila_pkg::Y_W-1:0]     top_q;
	logic                          ovf_q;

	// Output register
	logic                          out_vld_q;
	logic [ffila_pkg::LAYER_W-1:0] out_layer_q;
	logic [ffila_pkg::Y_W-1:0]     out_top_q;
	logic [ffila_pkg::Y_W-1:0]     out_bottom_q;
	logic [ffila_pkg::LAYER_W-1:0] out_max_q;
	logic                          out_ovf_q;

	// Combinational helpers
	logic                          in_acc;
	logic                          scan_more;
	logic                          store_full;
	logic [ffila_pkg::GRP_N-1:0]   grp_bits;
	logic                          grp_full;
	logic [ffila_pkg::LAYER_W-1:0] found_layer;
	logic [ffila_pkg::SUM_W-1:0]   pitch;
	logic [ffila_pkg::Y_W-1:0]     top_prod;
	logic [ffila_pkg::Y_W-1:0]     bottom_sum;
	logic                          out_load;

	// RAM ports
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [ffila_pkg::ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [ffila_pkg::ENTRY_W-1:0] ram_rdata;
	logic [ffila_pkg::TIME_W-1:0]  rd_finish;
	logic [ffila_pkg::LAYER_W-1:0] rd_layer;

	// ---------------------------------------------------------------- APB port
	// Always ready; paddr[2] picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			ffila_pkg::REG_BOX_HEIGHT: prdata = {{(ffila_pkg::APB_DATA_W - ffila_pkg::CFG_W){1'b0}},
			                                     box_height_q};
			ffila_pkg::REG_BOX_GAP:    prdata = {{(ffila_pkg::APB_DATA_W - ffila_pkg::CFG_W){1'b0}},
			                                     box_gap_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_height_q <= ffila_pkg::BOX_HEIGHT_RST;
			box_gap_q    <= ffila_pkg::BOX_GAP_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				ffila_pkg::REG_BOX_HEIGHT: box_height_q <= pwdata[ffila_pkg::CFG_W-1:0];
				ffila_pkg::REG_BOX_GAP:    box_gap_q    <= pwdata[ffila_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- store RAM
	// Each entry packs {finish time, layer}.
	assign store_full = (count_q >= CW'(MAX_ITEMS));
	assign scan_more  = (idx_q < count_q);
	assign ram_raddr  = idx_q[AW-1:0];
	assign ram_we     = (state_q == ffila_pkg::ST_CALC) && !store_full;
	assign ram_waddr  = count_q[AW-1:0];
	assign ram_wdata  = {finish_q, layer_q};
	assign rd_finish  = ram_rdata[ffila_pkg::ENTRY_W-1:ffila_pkg::LAYER_W];
	assign rd_layer   = ram_rdata[ffila_pkg::LAYER_W-1:0];

	ffila_ram #(
		.WIDTH(ffila_pkg::ENTRY_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------- search and arithmetic
	// Look at one byte of the blocked mask per cycle.
	assign grp_bits    = blocked_q[grp_q*ffila_pkg::GRP_N +: ffila_pkg::GRP_N];
	assign grp_full    = &grp_bits;
	assign found_layer = {grp_q, ffila_pkg::lowest_zero8(grp_bits)};

	assign pitch      = {1'b0, box_height_q} + {1'b0, box_gap_q};
	assign top_prod   = ffila_pkg::Y_W'(layer_q * pitch);
	assign bottom_sum = top_q + ffila_pkg::Y_W'(box_height_q);

	assign in_acc   = in_item.valid && in_item.ready;
	assign out_load = (state_q == ffila_pkg::ST_DONE) && (!out_vld_q || out_item.ready);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffila_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_item.ready = 1'b0;
		case (state_q)
			ffila_pkg::ST_IDLE: begin
				in_item.ready = 1'b1;
				if (in_item.valid) begin
					state_d = ffila_pkg::ST_SCAN;
				end
			end
			ffila_pkg::ST_SCAN: begin
				// Leave once every entry has been read and its data compared.
				if (!scan_more && !pend_q) begin
					state_d = ffila_pkg::ST_FIND;
				end
			end
			ffila_pkg::ST_FIND: begin
				if (!grp_full || grp_q == ffila_pkg::GRP_LAST) begin
					state_d = ffila_pkg::ST_CALC;
				end
			end
			ffila_pkg::ST_CALC: begin
				state_d = ffila_pkg::ST_DONE;
			end
			ffila_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ffila_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffila_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			highest_q <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			grp_q     <= '0;
		end else begin
			case (state_q)
				ffila_pkg::ST_IDLE: begin
					if (in_acc) begin
						// Start a new set: drop the stored intervals.
						if (in_item.is_first) begin
							count_q   <= '0;
							highest_q <= '0;
						end
						idx_q  <= '0;
						pend_q <= 1'b0;
						grp_q  <= '0;
					end
				end
				ffila_pkg::ST_SCAN: begin
					// Issue one read per cycle; data comes back in the next cycle.
					pend_q <= scan_more;
					if (scan_more) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ffila_pkg::ST_FIND: begin
					if (grp_full && grp_q != ffila_pkg::GRP_LAST) begin
						grp_q <= grp_q + ffila_pkg::GRP_W'(1);
					end
				end
				ffila_pkg::ST_CALC: begin
					if (layer_q > highest_q) begin
						highest_q <= layer_q;
					end
					if (!store_full) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_q   <= in_item.start_time;
			finish_q  <= in_item.finish_time;
			blocked_q <= '0;
		end else if (state_q == ffila_pkg::ST_SCAN && pend_q && start_q < rd_finish) begin
			blocked_q[rd_layer] <= 1'b1;
		end
		if (state_q == ffila_pkg::ST_FIND) begin
			// Every layer blocked: saturate at the top layer.
			layer_q <= grp_full ? ffila_pkg::LAYER_TOP : found_layer;
		end
		if (state_q == ffila_pkg::ST_CALC) begin
			top_q <= top_prod;
			ovf_q <= store_full;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_item.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_layer_q  <= layer_q;
			out_top_q    <= top_q;
			out_bottom_q <= bottom_sum;
			out_max_q    <= highest_q;
			out_ovf_q    <= ovf_q;
		end
	end

	assign out_item.valid     = out_vld_q;
	assign out_item.layer     = out_layer_q;
	assign out_item.top_y     = out_top_q;
	assign out_item.bottom_y  = out_bottom_q;
	assign out_item.max_layer = out_max_q;
	assign out_item.overflow  = out_ovf_q;

	// ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("store count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffila_pkg::ST_CALC && !store_full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("stored interval not counted");

	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q == ffila_pkg::ST_SCAN))
		else $error("read pending outside scan");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ffila_pkg::ST_DONE))
		else $error("result shown without finishing an item");
`endif

endmodule

[bench/first_fit_interval_layer_assign_top_tb.sv]
// Self-checking bench for first_fit_interval_layer_assign_top: interval items in, box items out,
// box registers over the APB port. Depends on ffila_pkg, ffila_in_if/ffila_out_if and the RTL.
// Results are predicted in the bench and compared field by field in order of arrival.
module first_fit_interval_layer_assign_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Package constants used throughout the bench
	localparam int unsigned APB_ADDR_W = ffila_pkg::APB_ADDR_W;
	localparam int unsigned APB_DATA_W = ffila_pkg::APB_DATA_W;
	localparam int unsigned TIME_W     = ffila_pkg::TIME_W;
	localparam int unsigned LAYER_W    = ffila_pkg::LAYER_W;
	localparam int unsigned Y_W        = ffila_pkg::Y_W;
	localparam int unsigned CFG_W      = ffila_pkg::CFG_W;
	localparam int unsigned LAYERS     = ffila_pkg::LAYERS;
	localparam logic REG_BOX_HEIGHT = ffila_pkg::REG_BOX_HEIGHT;
	localparam logic REG_BOX_GAP    = ffila_pkg::REG_BOX_GAP;
	localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = ffila_pkg::BOX_HEIGHT_RST;
	localparam logic [CFG_W-1:0] BOX_GAP_RST    = ffila_pkg::BOX_GAP_RST;

	// Store depth of the block under test; the predictor keeps a store of the same size
	localparam int unsigned STORE_DEPTH = 64;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 170;
	// The slowest item is a full store scan plus search and output
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned HOLD_AFTER    = 300;
	localparam int unsigned MAX_REPORTS   = 40;
	localparam int unsigned TIMEOUT_NS    = 2_000_000;

	localparam logic [APB_ADDR_W-1:0] ADDR_BOX_HEIGHT = {REG_BOX_HEIGHT, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_BOX_GAP    = {REG_BOX_GAP, 2'b00};

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// One result item as the block presents it
	typedef struct packed {
		logic [LAYER_W-1:0] layer;
		logic [Y_W-1:0]     top_y;
		logic [Y_W-1:0]     bottom_y;
		logic [LAYER_W-1:0] max_layer;
		logic               overflow;
	} box_t;

	// One row of the directed table; typed rows carry their own expected box
	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] finish_time;
		logic              is_first;
		logic              typed;
		box_t              want;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 14;

	// Reset values are height 20 and gap 3, so one layer is 23 units tall.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty store after reset, no set start flag
		'{24'd0,      24'd100,    1'b0, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd0, 1'b0}},
		// overlaps the first interval
		'{24'd50,     24'd200,    1'b0, 1'b1, '{6'd1, 15'd23, 15'd43, 6'd1, 1'b0}},
		// finish equal to start does not block
		'{24'd100,    24'd150,    1'b0, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd1, 1'b0}},
		// largest start, nothing blocks
		'{TIME_MAX,   TIME_MAX,   1'b0, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd1, 1'b0}},
		// zero start, zero length: layers 0 and 1 blocked
		'{24'd0,      24'd0,      1'b0, 1'b1, '{6'd2, 15'd46, 15'd66, 6'd2, 1'b0}},
		// new set clears store and highest layer
		'{24'd0,      TIME_MAX,   1'b1, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd0, 1'b0}},
		// finish before start, stored as given
		'{24'hFFFFFE, 24'd0,      1'b0, 1'b1, '{6'd1, 15'd23, 15'd43, 6'd1, 1'b0}},
		'{24'd0,      24'd5,      1'b0, 1'b1, '{6'd1, 15'd23, 15'd43, 6'd1, 1'b0}},
		'{24'd4,      24'd10,     1'b0, 1'b1, '{6'd2, 15'd46, 15'd66, 6'd2, 1'b0}},
		'{24'h800000, 24'h7FFFFF, 1'b1, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd0, 1'b0}},
		'{24'h7FFFFF, 24'hAAAAAA, 1'b0, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd0, 1'b0}},
		'{24'h555555, 24'h555556, 1'b0, 1'b1, '{6'd1, 15'd23, 15'd43, 6'd1, 1'b0}},
		'{24'h555556, TIME_MAX,   1'b0, 1'b0, '0},
		'{TIME_MAX,   TIME_MAX,   1'b1, 1'b1, '{6'd0, 15'd0,  15'd20, 6'd0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ffila_in_if  in_ch ();
	ffila_out_if out_ch ();

	first_fit_interval_layer_assign_top #(
		.MAX_ITEMS(STORE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_ch),
		.out_item(out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: mirror of the box registers and of the interval store
	logic [CFG_W-1:0]   box_h = BOX_HEIGHT_RST;
	logic [CFG_W-1:0]   box_g = BOX_GAP_RST;
	logic [TIME_W-1:0]  held_finish [STORE_DEPTH];
	logic [LAYER_W-1:0] held_layer  [STORE_DEPTH];
	int unsigned        held_count = 0;
	logic [LAYER_W-1:0] top_layer = '0;

	// Boxes predicted for accepted intervals, oldest first
	box_t awaited_boxes [$];

	int unsigned err_count = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_overflow = 0;
	int unsigned highest_seen = 0;
	bit          calm = 1'b0;     // no idling on either side while set
	bit          hold_off = 1'b0; // long receiver stall, driven by its own process

	// Place one interval: lowest layer that no stored interval finishing after the
	// new start occupies. If all 64 layers are taken the layer sticks at the top one.
	function automatic box_t place_interval(input logic [TIME_W-1:0] s_t,
			input logic [TIME_W-1:0] f_t, input logic first);
		logic [LAYERS-1:0] blocked;
		int unsigned       lay;
		int unsigned       pitch;
		int unsigned       top;
		box_t              b;
		blocked = '0;
		if (first) begin
			held_count = 0;
			top_layer  = '0;
		end
		for (int i = 0; i < held_count; i++) begin
			if (s_t < held_finish[i]) begin
				blocked[held_layer[i]] = 1'b1;
			end
		end
		lay = LAYERS - 1;
		for (int l = LAYERS - 1; l >= 0; l--) begin
			if (!blocked[l]) begin
				lay = l;
			end
		end
		if (lay > top_layer) begin
			top_layer = LAYER_W'(lay);
		end
		// a full store keeps its contents; the interval is only flagged
		if (held_count < STORE_DEPTH) begin
			held_finish[held_count] = f_t;
			held_layer[held_count]  = LAYER_W'(lay);
			held_count++;
			b.overflow = 1'b0;
		end else begin
			b.overflow = 1'b1;
		end
		pitch      = box_h + box_g;
		top        = lay * pitch;
		b.layer     = LAYER_W'(lay);
		b.top_y     = Y_W'(top);
		b.bottom_y  = Y_W'(top + box_h);
		b.max_layer = top_layer;
		return b;
	endfunction

	task automatic note_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
	endtask

	// Offer one interval; hold it until the block takes it, then predict its box.
	// Called right after a rising edge, and returns right after the accepting edge.
	task automatic offer_interval(input logic [TIME_W-1:0] s_t, input logic [TIME_W-1:0] f_t,
			input logic first, input logic typed, input box_t want);
		box_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.start_time  <= s_t;
		in_ch.finish_time <= f_t;
		in_ch.is_first    <= first;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = place_interval(s_t, f_t, first);
		awaited_boxes.insert(awaited_boxes.size(), typed ? want : predicted);
		n_sent++;
	endtask

	// APB write: setup cycle, then access until pready. Leaves psel up so a second
	// write can follow without a drop; the caller releases the bus.
	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
	endtask

	// Drain all pending boxes, let the block settle, then load new box registers
	task automatic set_box_size(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] g);
		in_ch.valid <= 1'b0;
		while (awaited_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ADDR_BOX_HEIGHT, h);
		write_reg(ADDR_BOX_GAP, g);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		box_h = h;
		box_g = g;
	endtask

	// Random sets of intervals. Most are timelines like a build order: starts ascend,
	// each lasts a while, the set opens with is_first. Some are long enough to fill
	// the store, some stack every interval on top of the last to reach layer 63,
	// some continue the previous set without a new start, and a few are pure noise.
	task automatic run_phase(input int unsigned budget);
		int unsigned       done_n;
		int unsigned       len;
		int unsigned       kind;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] s_t;
		logic [TIME_W-1:0] f_t;
		logic              first;
		done_n = 0;
		while (done_n < budget) begin
			kind = $urandom_range(0, 9);
			case (kind)
			5: begin
				len = $urandom_range(60, 72);
			end
			6: begin
				len = $urandom_range(64, 70);
			end
			8: begin
				len = $urandom_range(1, 8);
			end
			default: begin
				len = $urandom_range(1, 24);
			end
			endcase
			// now and then start anywhere in the time range so times can wrap
			t = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 5000));
			for (int i = 0; i < len; i++) begin
				case (kind)
				6: begin
					s_t = t + TIME_W'(i);
					f_t = TIME_MAX - TIME_W'(i);
				end
				8: begin
					s_t = TIME_W'($urandom);
					f_t = TIME_W'($urandom);
				end
				default: begin
					s_t = t;
					f_t = t + TIME_W'($urandom_range(1, 300));
					t   = t + TIME_W'($urandom_range(0, 60));
				end
				endcase
				if (kind == 8) begin
					first = 1'($urandom_range(0, 1));
				end else begin
					first = (i == 0) && (kind != 9);
				end
				offer_interval(s_t, f_t, first, 1'b0, '0);
			end
			done_n += len;
		end
	endtask

	// Stimulus and end of run
	initial begin
		logic [CFG_W-1:0] h;
		logic [CFG_W-1:0] g;
		in_ch.valid       <= 1'b0;
		in_ch.start_time  <= '0;
		in_ch.finish_time <= '0;
		in_ch.is_first    <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset box size
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer_interval(directed_rows[r].start_time, directed_rows[r].finish_time,
				directed_rows[r].is_first, directed_rows[r].typed, directed_rows[r].want);
		end

		// Random phases, each with its own box size; extremes first, reset size last
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: begin
				h = 8'd255;
				g = 8'd255;
			end
			1: begin
				h = 8'd1;
				g = 8'd0;
			end
			2: begin
				// zero height is out of range but computed as given
				h = 8'd0;
				g = 8'd255;
			end
			3: begin
				h = 8'd255;
				g = 8'd0;
			end
			PHASES - 1: begin
				h = BOX_HEIGHT_RST;
				g = BOX_GAP_RST;
			end
			default: begin
				h = CFG_W'($urandom_range(1, 255));
				g = CFG_W'($urandom_range(0, 255));
			end
			endcase
			set_box_size(h, g);
			// one stretch mid-run and the tail run with no idling at all
			calm = (p == 3) || (p == PHASES - 1);
			run_phase(PHASE_ITEMS);
		end

		in_ch.valid <= 1'b0;
		while (awaited_boxes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d intervals sent, %0d boxes checked, %0d flagged overflow",
			n_sent, n_checked, n_overflow);
		$display("Run: highest layer seen %0d, box sizes from 0 to 255, %0d-cycle output stall",
			highest_seen, HOLD_CYCLES);
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Result side: check each accepted box against the oldest prediction, then pick
	// the next value of ready (short random stalls, or the long hold-off)
	initial begin
		box_t        got;
		box_t        want;
		int unsigned stall_left;
		logic        rdy;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got = '{out_ch.layer, out_ch.top_y, out_ch.bottom_y, out_ch.max_layer,
					out_ch.overflow};
				if (awaited_boxes.size() == 0) begin
					note_mismatch($sformatf("box with no interval pending: layer %0d", got.layer));
				end else begin
					want = awaited_boxes.pop_front();
					n_checked++;
					if (got.layer !== want.layer) begin
						note_mismatch($sformatf("layer %0d, predicted %0d", got.layer, want.layer));
					end
					if (got.top_y !== want.top_y) begin
						note_mismatch($sformatf("top_y %0d, predicted %0d", got.top_y, want.top_y));
					end
					if (got.bottom_y !== want.bottom_y) begin
						note_mismatch($sformatf("bottom_y %0d, predicted %0d",
							got.bottom_y, want.bottom_y));
					end
					if (got.max_layer !== want.max_layer) begin
						note_mismatch($sformatf("max_layer %0d, predicted %0d",
							got.max_layer, want.max_layer));
					end
					if (got.overflow !== want.overflow) begin
						note_mismatch($sformatf("overflow %0b, predicted %0b",
							got.overflow, want.overflow));
					end
					if (want.overflow) begin
						n_overflow++;
					end
					if (want.layer > highest_seen) begin
						highest_seen = want.layer;
					end
				end
			end
			if (hold_off) begin
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			out_ch.ready <= rdy;
		end
	end

	// Long output stall once the run is under way: the block fills and must stop
	// taking intervals while the sender keeps offering. Toggle on the falling edge
	// so the result side sees a settled value.
	initial begin
		while (n_sent < HOLD_AFTER) @(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d boxes still pending", awaited_boxes.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/ffila_pkg.sv
rtl/ffila_if.sv
rtl/ffila_ram.sv
rtl/first_fit_interval_layer_assign_top.sv
bench/first_fit_interval_layer_assign_top_tb.sv
